// File: src/strs_pkg.sv
// Shared widths, defaults and item codes for the sorted table rank search.
package strs_pkg;

    localparam int CountWidth        = 11;
    localparam int SlotWidth         = 10;
    localparam int PosWidth          = 31;
    localparam int DefaultTableDepth = 1024;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

// File: src/strs_pos_ram.sv
// Position table: single write port, single registered read port.
module strs_pos_ram
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = DefaultTableDepth,
    parameter int AddrWidth   = $clog2(TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AddrWidth-1:0] i_waddr,
    input  logic [PosWidth-1:0]  i_wdata,
    input  logic [AddrWidth-1:0] i_raddr,
    output logic [PosWidth-1:0]  o_rdata
);

    logic [PosWidth-1:0] r_mem [TABLE_DEPTH];
    logic [PosWidth-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sorted_table_rank_search.sv
// Top level: position table with a binary search sequencer for rank queries.
//
// A load (op 0) writes one table entry in the cycle it is accepted and gives no
// result; busy stays low, so a load can be taken every cycle while no query is
// running. A query (op 1) returns the number of entries, among the first
// entry_count, that lie before the queried position. A query reads the single
// table port once per cycle: entry 0, then entry n-1, then one binary search
// probe per cycle. The result strobe is registered: it is set from S_IDLE for
// an empty-table query, from S_CHK_FIRST for one below the first entry, from
// S_CHK_LAST for one above the last entry and from S_PROBE otherwise. busy is
// high while the sequencer is out of S_IDLE and low again in the strobe cycle.
// The result stays on o_count_before from the one-cycle strobe until the next
// result, and the receiver cannot stall it. Write entry_count only while busy
// is low.
module sorted_table_rank_search
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = DefaultTableDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [SlotWidth-1:0]  i_slot,
    input  logic [PosWidth-1:0]   i_position,
    input  logic                  i_cfg_we,
    input  logic [CountWidth-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output logic [CountWidth-1:0] o_count_before
);

    localparam int AddrWidth = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_PROBE
    } t_state;

    t_state                r_state;
    logic [CountWidth-1:0] r_entry_count;
    logic [PosWidth-1:0]   r_pos;
    logic [CountWidth-1:0] r_n;
    logic [CountWidth-1:0] r_lo;
    logic [CountWidth-1:0] r_hip1;
    logic [CountWidth-1:0] r_mid;
    logic                  r_strobe;
    logic [CountWidth-1:0] r_count;

    logic [CountWidth-1:0] n_raddr_idx;
    logic [AddrWidth-1:0]  n_raddr;
    logic [AddrWidth-1:0]  waddr;
    logic                  we;
    logic [PosWidth-1:0]   rdata;
    logic                  accept;
    logic [CountWidth-1:0] n_eff;
    logic [CountWidth-1:0] lo_nx;
    logic [CountWidth-1:0] hip1_nx;
    logic [CountWidth:0]   mid_sum;
    logic [CountWidth:0]   last_sum;
    logic [AddrWidth+CountWidth-1:0] raddr_ext;
    logic [AddrWidth+SlotWidth-1:0]  waddr_ext;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            n_eff = CountWidth'(TABLE_DEPTH);
        end else begin
            n_eff = r_entry_count;
        end
    end

    // Drop loads to slots beyond the table.
    assign we        = accept && (t_op'(i_op) == OP_LOAD) && (32'(i_slot) < TABLE_DEPTH);
    assign waddr_ext = {AddrWidth'(0), i_slot};
    assign waddr     = waddr_ext[AddrWidth-1:0];

    // Narrow the search window after the current probe.
    always_comb begin
        lo_nx   = r_lo;
        hip1_nx = r_hip1;
        if (rdata < r_pos) begin
            lo_nx = r_mid + CountWidth'(1);
        end else begin
            hip1_nx = r_mid;
        end
        mid_sum  = {1'b0, lo_nx} + {1'b0, hip1_nx} - (CountWidth+1)'(1);
        last_sum = {1'b0, r_n} - (CountWidth+1)'(1);
    end

    always_comb begin
        case (r_state)
            S_CHK_FIRST: n_raddr_idx = last_sum[CountWidth-1:0];
            S_CHK_LAST:  n_raddr_idx = last_sum[CountWidth:1];
            S_PROBE:     n_raddr_idx = mid_sum[CountWidth:1];
            default:     n_raddr_idx = '0;
        endcase
        raddr_ext = {AddrWidth'(0), n_raddr_idx};
        n_raddr   = raddr_ext[AddrWidth-1:0];
    end

    strs_pos_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_position),
        .i_raddr (n_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (t_op'(i_op) == OP_QUERY)) begin
                        r_pos <= i_position;
                        r_n   <= n_eff;
                        if (n_eff == '0) begin
                            r_strobe <= 1'b1;
                            r_count  <= '0;
                        end else begin
                            r_state <= S_CHK_FIRST;
                        end
                    end
                end
                S_CHK_FIRST: begin
                    if (r_pos < rdata) begin
                        r_strobe <= 1'b1;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST: begin
                    if (r_pos > rdata) begin
                        r_strobe <= 1'b1;
                        r_count  <= r_n;
                        r_state  <= S_IDLE;
                    end else begin
                        r_lo    <= '0;
                        r_hip1  <= r_n;
                        r_mid   <= last_sum[CountWidth:1];
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (rdata == r_pos) begin
                        r_strobe <= 1'b1;
                        r_count  <= r_mid;
                        r_state  <= S_IDLE;
                    end else if (lo_nx < hip1_nx) begin
                        r_lo   <= lo_nx;
                        r_hip1 <= hip1_nx;
                        r_mid  <= mid_sum[CountWidth:1];
                    end else begin
                        r_strobe <= 1'b1;
                        r_count  <= hip1_nx;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_count_before = r_count;

endmodule

// File: sim/sorted_table_rank_search_test.sv
// Testbench for sorted_table_rank_search: random load/query traffic checked against a rank predictor.
module sorted_table_rank_search_test;
    import strs_pkg::*;

    localparam int          Depth        = DefaultTableDepth;
    localparam int unsigned PosMax       = 32'h7FFF_FFFF;
    localparam int          QuietLimit   = 2000;
    localparam int          SettleCycles = 16;
    localparam int          ReportLimit  = 10;

    typedef struct {
        t_op                  op;
        logic [SlotWidth-1:0] slot;
        logic [PosWidth-1:0]  pos;
    } t_search_cmd;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  i_op        = OP_LOAD;
    logic [SlotWidth-1:0]  i_slot      = '0;
    logic [PosWidth-1:0]   i_position  = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CountWidth-1:0] i_cfg_wdata = '0;
    logic                  o_strobe;
    logic [CountWidth-1:0] o_count_before;

    // Checker side: mirror of the table and the count register.
    logic [PosWidth-1:0]   pos_store [Depth];
    logic [CountWidth-1:0] held_count = '0;
    logic [CountWidth-1:0] expected_ranks [$];
    int                    fail_count  = 0;
    int                    quiet_cycles = 0;
    bit                    took_item   = 1'b0;

    // Stimulus side: commands waiting for the driver and the table they build.
    t_search_cmd           pending_items [$];
    int unsigned           plan_table [Depth];
    int                    plan_n   = 0;
    int                    idle_pct = 28;

    sorted_table_rank_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_position     (i_position),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_count_before (o_count_before)
    );

    always #6 i_clk = ~i_clk;

    // Lower-bound binary search with the block's probe order.
    function automatic logic [CountWidth-1:0] rank_before(input logic [PosWidth-1:0] pos);
        int n;
        int lo;
        int hi;
        int mid;
        n = (int'(held_count) > Depth) ? Depth : int'(held_count);
        if (n == 0) return '0;
        if (pos < pos_store[0]) return '0;
        if (pos > pos_store[n-1]) return CountWidth'(n);
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (pos_store[mid] == pos) return CountWidth'(mid);
            if (pos_store[mid] < pos) lo = mid + 1;
            else hi = mid - 1;
        end
        return CountWidth'(hi + 1);
    endfunction

    // Driver: hold start until the transfer, then present the next command.
    always @(negedge i_clk) begin : drive
        logic        go;
        t_search_cmd next_cmd;
        if (took_item) pending_items.delete(0);
        go = 1'b0;
        if (i_rst_n && pending_items.size() != 0)
            go = (start && !took_item) || ($urandom_range(99) >= idle_pct);
        if (go) begin
            next_cmd   = pending_items[0];
            start      <= 1'b1;
            i_op       <= next_cmd.op;
            i_slot     <= next_cmd.slot;
            i_position <= next_cmd.pos;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check results first, then apply config writes and transfers.
    always @(posedge i_clk) begin : monitor
        logic [CountWidth-1:0] want;
        bit                    moved;
        took_item = 1'b0;
        moved     = 1'b0;
        if (i_rst_n) begin
            if (o_strobe) begin
                moved = 1'b1;
                if (expected_ranks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ReportLimit)
                        $display("unexpected result: count_before %0d", o_count_before);
                end else begin
                    want = expected_ranks.pop_front();
                    if (o_count_before !== want) begin
                        fail_count++;
                        if (fail_count <= ReportLimit)
                            $display("count_before mismatch: expected %0d, actual %0d",
                                     want, o_count_before);
                    end
                end
            end
            if (i_cfg_we) begin
                held_count = i_cfg_wdata;
                moved      = 1'b1;
            end
            if (start && !busy) begin
                took_item = 1'b1;
                moved     = 1'b1;
                if (i_op == OP_LOAD) pos_store[i_slot] = i_position;
                else expected_ranks.push_back(rank_before(i_position));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_load(input int slot, input int unsigned pos);
        t_search_cmd cmd;
        cmd.op   = OP_LOAD;
        cmd.slot = SlotWidth'(slot);
        cmd.pos  = PosWidth'(pos);
        pending_items.push_back(cmd);
        plan_table[slot] = pos & PosMax;
    endtask

    task automatic push_query(input int unsigned pos);
        t_search_cmd cmd;
        cmd.op   = OP_QUERY;
        cmd.slot = SlotWidth'($urandom);
        cmd.pos  = PosWidth'(pos);
        pending_items.push_back(cmd);
    endtask

    // Write slots 0..n-1 with strictly increasing positions.
    task automatic fill_sorted(input int n, input int unsigned gap, input bit zero_first);
        int unsigned v;
        v = zero_first ? 0 : $urandom_range(gap, 1);
        for (int k = 0; k < n; k++) begin
            push_load(k, v);
            v += $urandom_range(gap, 1);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || start || expected_ranks.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_count(input int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CountWidth'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        plan_n = (value > Depth) ? Depth : value;
    endtask

    // Mostly sort-keeping loads and queries aimed at entries; a little noise.
    task automatic run_mix(input int items);
        int          r;
        int          k;
        int unsigned lo;
        int unsigned hi;
        int unsigned base;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                push_load($urandom_range(Depth - 1), $urandom & PosMax);
            end else if (r < 14 && plan_n > 0) begin
                k  = $urandom_range(plan_n - 1);
                lo = (k == 0) ? 0 : plan_table[k-1] + 1;
                hi = (k == plan_n - 1) ? PosMax : plan_table[k+1] - 1;
                if (lo <= hi && hi <= PosMax) push_load(k, $urandom_range(hi, lo));
                else push_load(k, plan_table[k]);
            end else if (r < 14) begin
                push_load($urandom_range(Depth - 1), $urandom & PosMax);
            end else begin
                r = $urandom_range(9);
                if (r == 0 || plan_n == 0 && r > 2) begin
                    push_query($urandom & PosMax);
                end else if (r == 1) begin
                    push_query(0);
                end else if (r == 2) begin
                    push_query(PosMax);
                end else begin
                    base = plan_table[$urandom_range(plan_n - 1)];
                    case ($urandom_range(3))
                        0:       push_query((base == 0) ? 0 : base - 1);
                        3:       push_query((base == PosMax) ? base : base + 1);
                        default: push_query(base);
                    endcase
                end
            end
        end
    endtask

    initial begin : stimulus
        int settings [12];
        int n;
        settings = '{3, 1024, 40, 2047, 1, 0, 2, 1025, 17, 1023, 9, 1024};
        settings[5] = $urandom_range(1000, 65);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table answers zero for any position.
        push_query(0);
        push_query(PosMax);

        fill_sorted(Depth, 2_000_000, 1'b0);
        write_count(Depth);
        push_query(0);
        push_query(plan_table[0]);
        push_query(plan_table[0] + 1);
        push_query(plan_table[511] - 1);
        push_query(plan_table[511]);
        push_query(plan_table[Depth-1]);
        push_query(plan_table[Depth-1] + 1);
        push_query(PosMax);

        // Counts beyond the table depth saturate.
        write_count(2047);
        push_query(PosMax);
        push_query(plan_table[Depth-1]);
        push_query(plan_table[0] - 1);
        write_count(Depth + 1);
        push_query(PosMax);

        // Single entry at both ends of the position range.
        write_count(1);
        push_load(0, PosMax);
        push_query(PosMax);
        push_query(PosMax - 1);
        push_load(0, 0);
        push_query(0);
        push_query(5);

        for (int p = 0; p < 12; p++) begin
            idle_pct = (p < 4) ? 28 : (p < 8) ? 88 : 0;
            n = settings[p];
            if (n > 0 && n <= 64)
                fill_sorted(n, $urandom_range(1) ? 3 : PosMax / (n + 1),
                            $urandom_range(3) == 0);
            write_count(n);
            run_mix(3);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
